/* hdl/vdt_pkg.sv */
// ----------------------------------------------------------------------------
// vdt_pkg
// Shared types, sizes and the float compare for the vertex dedup table.
// ----------------------------------------------------------------------------
package vdt_pkg;

  localparam int TableDepth = 64;
  localparam int IdxW       = $clog2(TableDepth + 1);
  localparam int NumWords   = 8;

  typedef logic [NumWords-1:0][31:0] vtx_t;

  typedef struct packed {
    logic            active;
    logic            done;
    logic            is_new;
    logic [IdxW-1:0] idx;
  } token_t;

  function automatic logic word_is_nan(input logic [31:0] w);
    return w[30:0] > 31'h7F80_0000;
  endfunction

  function automatic logic fp_eq(input logic [31:0] a, input logic [31:0] b);
    logic res;
    if (word_is_nan(a) || word_is_nan(b)) begin
      res = 1'b0;
    end else if ((a[30:0] | b[30:0]) == 31'd0) begin
      res = 1'b1;
    end else begin
      res = (a == b);
    end
    return res;
  endfunction

endpackage

/* hdl/vertex_dedup_table_top.sv */
// ----------------------------------------------------------------------------
// vertex_dedup_table_top
// Welds a vertex stream into a table of unique vertices; one result per beat.
// ----------------------------------------------------------------------------
//  channel | direction | handshake                 | payload
//  in      | sink      | in_valid_i / in_stall_o   | start_new_mesh_i, 8 float words
//  out     | source    | out_valid_o / out_stall_i | vertex_index_o, is_new_o, table_full_o
//
//  A search token walks the cell chain one slot per cycle, from launch_q
//  through the cells to pend_q and out_q; one vertex in flight at a time.
//  The next input beat is taken once the result sits in the output register.
//  Reset empties the table; entry payload is not cleared.
//  Output stalls hold the result and, once the next search ends, the input.
// ----------------------------------------------------------------------------
module vertex_dedup_table_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic        start_new_mesh_i,
  input  logic [31:0] pos_x_i,
  input  logic [31:0] pos_y_i,
  input  logic [31:0] pos_z_i,
  input  logic [31:0] normal_x_i,
  input  logic [31:0] normal_y_i,
  input  logic [31:0] normal_z_i,
  input  logic [31:0] tex_u_i,
  input  logic [31:0] tex_v_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [vdt_pkg::IdxW-1:0] vertex_index_o,
  output logic        is_new_o,
  output logic        table_full_o
);
  import vdt_pkg::*;

  vtx_t   vtx_q;
  logic   busy_q, launch_q, pend_valid_q, out_valid_q;
  token_t pend_q, out_q;
  token_t chain [TableDepth+1];
  logic   accept, clr, move;

  assign accept = in_valid_i && !busy_q;
  assign clr    = accept && start_new_mesh_i;
  assign move   = pend_valid_q && (!out_valid_q || !out_stall_i);

  always_ff @(posedge clk_i) begin
    if (accept) begin
      vtx_q <= {tex_v_i, tex_u_i, normal_z_i, normal_y_i, normal_x_i,
                pos_z_i, pos_y_i, pos_x_i};
    end
  end

  always_comb begin
    chain[0]        = '0;
    chain[0].active = launch_q;
  end

  for (genvar g = 0; g < TableDepth; g++) begin : g_cell
    vdt_cell u_cell (
      .clk_i (clk_i),
      .rst_ni(rst_ni),
      .clr_i (clr),
      .vtx_i (vtx_q),
      .tok_i (chain[g]),
      .tok_o (chain[g+1])
    );
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q       <= 1'b0;
      launch_q     <= 1'b0;
      pend_valid_q <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      launch_q <= accept;
      if (accept) begin
        busy_q <= 1'b1;
      end else if (move) begin
        busy_q <= 1'b0;
      end
      if (chain[TableDepth].active) begin
        pend_valid_q <= 1'b1;
      end else if (move) begin
        pend_valid_q <= 1'b0;
      end
      if (move) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (chain[TableDepth].active) begin
      pend_q <= chain[TableDepth];
    end
    if (move) begin
      out_q <= pend_q;
    end
  end

  assign in_stall_o     = busy_q;
  assign out_valid_o    = out_valid_q;
  assign vertex_index_o = out_q.idx;
  assign is_new_o       = out_q.is_new;
  assign table_full_o   = !out_q.done;

endmodule

/* hdl/vdt_cell.sv */
// ----------------------------------------------------------------------------
// vdt_cell
// One table slot: holds an entry, tests it against the broadcast vertex when
// the search token passes, claims the slot on a miss at the first free cell.
// ----------------------------------------------------------------------------
module vdt_cell (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            clr_i,
  input  vdt_pkg::vtx_t   vtx_i,
  input  vdt_pkg::token_t tok_i,
  output vdt_pkg::token_t tok_o
);
  import vdt_pkg::*;

  vtx_t   entry_q;
  logic   valid_q, valid_d;
  token_t tok_q, tok_d;
  logic   match;
  logic   claim;

  always_comb begin
    match = valid_q;
    for (int w = 0; w < NumWords; w++) begin
      match = match & fp_eq(entry_q[w], vtx_i[w]);
    end
  end

  always_comb begin
    tok_d   = tok_i;
    claim   = 1'b0;
    valid_d = clr_i ? 1'b0 : valid_q;
    if (tok_i.active && !tok_i.done) begin
      if (match) begin
        tok_d.done = 1'b1;
      end else if (!valid_q) begin
        claim        = 1'b1;
        valid_d      = 1'b1;
        tok_d.done   = 1'b1;
        tok_d.is_new = 1'b1;
      end else begin
        tok_d.idx = tok_i.idx + IdxW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      tok_q   <= '0;
    end else begin
      valid_q <= valid_d;
      tok_q   <= tok_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (claim) begin
      entry_q <= vtx_i;
    end
  end

  assign tok_o = tok_q;

endmodule

/* hdl/vdt_checker.sv */
// ----------------------------------------------------------------------------
// vdt_checker
// Port-level checks on the vertex dedup table results.
// ----------------------------------------------------------------------------
module vdt_checker (
  input logic clk_i,
  input logic rst_ni,
  input logic out_valid_o,
  input logic out_stall_i,
  input logic [vdt_pkg::IdxW-1:0] vertex_index_o,
  input logic is_new_o,
  input logic table_full_o
);
  import vdt_pkg::*;

  a_full_idx: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && table_full_o |-> vertex_index_o == IdxW'(TableDepth))
    else $error("full result with wrong index");

  a_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !(is_new_o && table_full_o))
    else $error("new and full together");

  a_idx_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !table_full_o |-> vertex_index_o < IdxW'(TableDepth))
    else $error("index beyond table");

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(vertex_index_o))
    else $error("stalled beat changed");

endmodule

bind vertex_dedup_table_top vdt_checker u_vdt_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .out_valid_o   (out_valid_o),
  .out_stall_i   (out_stall_i),
  .vertex_index_o(vertex_index_o),
  .is_new_o      (is_new_o),
  .table_full_o  (table_full_o)
);

/* verif/vertex_dedup_table_top_tb.sv */
// ----------------------------------------------------------------------------
// vertex_dedup_table_top_tb
// Drives directed and random vertex beats into the dedup table and checks
// every result beat against a local model of the unique vertex table.
// ----------------------------------------------------------------------------
module vertex_dedup_table_top_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import vdt_pkg::*;

  localparam int LimitCycles = 400000;
  localparam logic [31:0] PosZero = 32'h0000_0000;
  localparam logic [31:0] NegZero = 32'h8000_0000;
  localparam logic [31:0] QNan    = 32'h7FC0_0000;
  localparam logic [31:0] PosInf  = 32'h7F80_0000;
  localparam logic [31:0] AllOnes = 32'hFFFF_FFFF;

  typedef struct {
    logic       start;
    vtx_t       words;
    logic       known;
    logic [IdxW-1:0] idx;
    logic       is_new;
    logic       full;
  } row_t;

  typedef struct packed {
    logic [IdxW-1:0] idx;
    logic            is_new;
    logic            full;
  } weld_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic start_mesh = 1'b0;
  vtx_t in_words = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [IdxW-1:0] vertex_index;
  logic is_new;
  logic table_full;

  vtx_t  welded[TableDepth];
  int    welded_count = 0;
  weld_t weld_q[$];
  int    errors = 0;
  int    cycles = 0;
  bit    hold_long = 0;
  int    rx_wait = 0;
  bit    rx_took = 1;
  vtx_t  seen_pool[$];

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  vertex_dedup_table_top dut (
    .clk_i(clk), .rst_ni(rst_n),
    .in_valid_i(in_valid), .in_stall_o(in_stall),
    .start_new_mesh_i(start_mesh),
    .pos_x_i(in_words[0]), .pos_y_i(in_words[1]), .pos_z_i(in_words[2]),
    .normal_x_i(in_words[3]), .normal_y_i(in_words[4]), .normal_z_i(in_words[5]),
    .tex_u_i(in_words[6]), .tex_v_i(in_words[7]),
    .out_valid_o(out_valid), .out_stall_i(out_stall),
    .vertex_index_o(vertex_index), .is_new_o(is_new), .table_full_o(table_full)
  );

  function automatic bit float_same(logic [31:0] a, logic [31:0] b);
    bit nan_a, nan_b;
    nan_a = a[30:0] > 31'h7F80_0000;
    nan_b = b[30:0] > 31'h7F80_0000;
    if (nan_a || nan_b) return 0;
    if ((a[30:0] | b[30:0]) == 31'd0) return 1;
    return a == b;
  endfunction

  function automatic weld_t weld_vertex(logic start, vtx_t v);
    weld_t r;
    bit hit;
    if (start) welded_count = 0;
    for (int s = 0; s < welded_count; s++) begin
      hit = 1;
      for (int w = 0; w < NumWords; w++)
        if (!float_same(welded[s][w], v[w])) hit = 0;
      if (hit) begin
        r.idx = IdxW'(s); r.is_new = 1'b0; r.full = 1'b0;
        return r;
      end
    end
    if (welded_count < TableDepth) begin
      welded[welded_count] = v;
      r.idx = IdxW'(welded_count); r.is_new = 1'b1; r.full = 1'b0;
      welded_count++;
    end else begin
      r.idx = IdxW'(TableDepth); r.is_new = 1'b0; r.full = 1'b1;
    end
    return r;
  endfunction

  // called at a falling edge; returns at the falling edge after the beat
  task automatic send_vertex(logic start, vtx_t v, bit known, weld_t want);
    weld_t got;
    int idle;
    idle = $urandom_range(0, 9);
    if (idle > 0) begin
      in_valid <= 1'b0;
      repeat (idle) @(negedge clk);
    end
    got = weld_vertex(start, v);
    if (known && got !== want) begin
      $display("%0t table model: expected %p actual %p", $time, want, got);
      errors++;
    end
    in_valid <= 1'b1;
    start_mesh <= start;
    in_words <= v;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    weld_q.push_back(got);
    seen_pool.push_back(v);
    if (seen_pool.size() > 40) void'(seen_pool.pop_front());
    @(negedge clk);
  endtask

  function automatic logic [31:0] rand_word();
    case ($urandom_range(0, 7))
      0: return PosZero;
      1: return NegZero;
      2: return QNan | $urandom_range(0, 255);
      3: return PosInf;
      4: return $urandom_range(0, 3) << 30;
      default: return $urandom();
    endcase
  endfunction

  function automatic vtx_t rand_vertex();
    vtx_t v;
    int pick;
    pick = $urandom_range(0, 9);
    if (pick < 5 && seen_pool.size() > 0) begin
      v = seen_pool[$urandom_range(0, seen_pool.size() - 1)];
      for (int w = 0; w < NumWords; w++)
        if (v[w][30:0] == 0 && $urandom_range(0, 1)) v[w][31] = ~v[w][31];
    end else if (pick < 8) begin
      for (int w = 0; w < NumWords; w++) v[w] = $urandom_range(0, 3) << 30;
    end else begin
      for (int w = 0; w < NumWords; w++) v[w] = rand_word();
    end
    return v;
  endfunction

  // receiver: random per-beat wait, one long hold-off
  always @(negedge clk) begin
    if (rx_took) begin
      rx_wait = $urandom_range(0, 9);
      rx_took = 0;
    end
    if (hold_long) begin
      out_stall <= 1'b1;
    end else if (rx_wait > 0 && out_valid) begin
      out_stall <= 1'b1;
      rx_wait--;
    end else begin
      out_stall <= (rx_wait > 0) ? 1'b1 : 1'b0;
    end
  end

  initial begin
    wait (rst_n);
    repeat (40) @(negedge clk);
    hold_long = 1;
    repeat (600) @(negedge clk);
    hold_long = 0;
  end

  always @(posedge clk) begin
    weld_t exp_r;
    if (rst_n && out_valid && !out_stall) begin
      rx_took = 1;
      if (weld_q.size() == 0) begin
        $display("%0t unexpected beat: actual idx=%0d new=%b full=%b", $time,
                 vertex_index, is_new, table_full);
        errors++;
      end else begin
        exp_r = weld_q.pop_front();
        if (vertex_index !== exp_r.idx || is_new !== exp_r.is_new ||
            table_full !== exp_r.full) begin
          $display("%0t result: expected idx=%0d new=%b full=%b actual idx=%0d new=%b full=%b",
                   $time, exp_r.idx, exp_r.is_new, exp_r.full,
                   vertex_index, is_new, table_full);
          errors++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > LimitCycles) begin
      $display("vertex_dedup_table_top: mismatch");
      $finish;
    end
  end

  initial begin
    row_t rows[$];
    row_t r;
    vtx_t v;
    weld_t w;
    repeat (8) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed
    r = '{1'b0, {8{PosZero}}, 1'b1, IdxW'(0), 1'b1, 1'b0};        rows.push_back(r);
    r = '{1'b0, {8{NegZero}}, 1'b1, IdxW'(0), 1'b0, 1'b0};        rows.push_back(r);
    r = '{1'b0, {8{AllOnes}}, 1'b1, IdxW'(1), 1'b1, 1'b0};        rows.push_back(r);
    r = '{1'b0, {8{AllOnes}}, 1'b1, IdxW'(2), 1'b1, 1'b0};        rows.push_back(r);
    r = '{1'b0, {8{QNan}}, 1'b1, IdxW'(3), 1'b1, 1'b0};           rows.push_back(r);
    r = '{1'b0, {8{32'h7FFF_FFFF}}, 1'b1, IdxW'(4), 1'b1, 1'b0};  rows.push_back(r);
    r = '{1'b0, {8{PosInf}}, 1'b1, IdxW'(5), 1'b1, 1'b0};         rows.push_back(r);
    r = '{1'b0, {8{PosInf}}, 1'b1, IdxW'(5), 1'b0, 1'b0};         rows.push_back(r);
    r = '{1'b0, {8{32'h3F80_0000}}, 1'b1, IdxW'(6), 1'b1, 1'b0};  rows.push_back(r);
    r = '{1'b1, {8{32'h3F80_0000}}, 1'b1, IdxW'(0), 1'b1, 1'b0};  rows.push_back(r);
    r = '{1'b0, {8{32'h3F80_0000}}, 1'b1, IdxW'(0), 1'b0, 1'b0};  rows.push_back(r);
    for (int i = 0; i < rows.size(); i++) begin
      w = '{rows[i].idx, rows[i].is_new, rows[i].full};
      send_vertex(rows[i].start, rows[i].words, rows[i].known, w);
    end
    // fill to full, then overflow
    for (int i = 1; i < TableDepth + 3; i++) begin
      v = {8{32'(i)}};
      send_vertex(1'b0, v, i >= TableDepth, '{IdxW'(TableDepth), 1'b0, 1'b1});
    end
    send_vertex(1'b0, {8{32'h3F80_0000}}, 1'b1, '{IdxW'(0), 1'b0, 1'b0});

    // random
    for (int n = 0; n < 420; n++) begin
      send_vertex($urandom_range(0, 59) == 0, rand_vertex(), 1'b0, '0);
    end
    in_valid <= 1'b0;

    while (weld_q.size() != 0) @(negedge clk);
    repeat (TableDepth + 10) @(negedge clk);
    if (errors == 0) $display("vertex_dedup_table_top: match");
    else $display("vertex_dedup_table_top: mismatch");
    $finish;
  end

endmodule
